>>> src/mma_pkg.sv
// shared constants, item types and control structs for the moving average unit
package mma_pkg;

  localparam int WINDOW   = 16;
  localparam int CHANNELS = 3;
  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 2;

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + FILL_W;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(SUM_W + 1);

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                window_full;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

>>> src/multichannel_moving_average_unit.sv
// top level of the multichannel moving average unit
//
//   channel | direction | valid     | stall     | payload
//   --------+-----------+-----------+-----------+------------------------------
//   in      | input     | in_valid  | in_stall  | in_data  (channel, sample)
//   out     | output    | out_valid | out_stall | out_data (average, window_full)
//
// one item at a time: accept, store read, update, then divide
// a new item is accepted only once the last one is handed off; the mean is formed
// by the bit-serial divider one quotient bit a cycle
// reset clears sums, fill counts and ring positions; the sample store needs no clearing
// a result stalled at the output holds the next item in the divider only;
// the next item is accepted while a result waits in the output register
module multichannel_moving_average_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mma_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mma_pkg::out_item_t  out_data
);
  import mma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mma_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  // a new result only appears at the end of an item's work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced without an item in progress");

  // reset leaves the unit empty and ready
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("unit not empty after reset");

endmodule

>>> src/mma_div.sv
// restoring divider, one quotient bit per cycle
module mma_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mma_pkg::SUM_W-1:0]  dividend,
  input  logic [mma_pkg::FILL_W-1:0] divisor,
  output logic [mma_pkg::SUM_W-1:0]  quotient,
  output logic                     done
);
  import mma_pkg::*;

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [FILL_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [FILL_W:0]   trial;
  logic              qbit;

  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    qbit  = (trial >= {1'b0, dvs_r});
    if (qbit) begin
      rem_nxt = FILL_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = FILL_W'(trial);
    end
    quo_nxt = {quo_r[SUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(SUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = (cnt_r == '0);

endmodule

>>> src/mma_datapath.sv
// per-channel window store, running sums, fill and ring state, divider and output register
module mma_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mma_pkg::cmd_t       cmd,
  output mma_pkg::sts_t       sts,
  input  mma_pkg::in_item_t   in_data,
  output mma_pkg::out_item_t  out_data,
  output logic                out_valid,
  input  logic                out_stall
);
  import mma_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic [CH_W-1:0]     ch_r;
  logic                bad_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [SAMPLE_W-1:0] rdata_r;
  logic                full_r;
  logic [SUM_W-1:0]    sum_r  [CHANNELS];
  logic [FILL_W-1:0]   fill_r [CHANNELS];
  logic [POS_W-1:0]    pos_r  [CHANNELS];
  out_item_t           out_r;
  logic                out_valid_r;

  logic [SUM_W-1:0]    cur_sum;
  logic [FILL_W-1:0]   cur_fill;
  logic [POS_W-1:0]    cur_pos;
  logic                is_full;
  logic [ADDR_W-1:0]   addr;
  logic [SUM_W-1:0]    new_sum;
  logic [POS_W-1:0]    pos_inc;
  logic [SUM_W-1:0]    dividend;
  logic [FILL_W-1:0]   divisor;
  logic [SUM_W-1:0]    quotient;
  logic                div_done;
  logic                in_bad;

  assign in_bad = (int'(in_data.channel) >= CHANNELS);

  always_comb begin
    cur_sum  = sum_r[ch_r];
    cur_fill = fill_r[ch_r];
    cur_pos  = pos_r[ch_r];
    is_full  = (cur_fill == FILL_W'(WINDOW));
    addr     = ADDR_W'(ch_r) * ADDR_W'(WINDOW)
             + (is_full ? ADDR_W'(cur_pos) : ADDR_W'(cur_fill));
    // oldest sample drops out only once the window is full
    new_sum  = cur_sum - (is_full ? SUM_W'(rdata_r) : '0) + SUM_W'(smp_r);
    pos_inc  = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + POS_W'(1);
    if (bad_r) begin
      dividend = '0;
      divisor  = FILL_W'(1);
    end else begin
      dividend = new_sum;
      divisor  = is_full ? FILL_W'(WINDOW) : cur_fill + FILL_W'(1);
    end
  end

  mma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.upd),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r  <= in_bad ? '0 : CH_W'(in_data.channel);
      bad_r <= in_bad;
      smp_r <= in_data.sample;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
    if (cmd.upd) begin
      full_r <= is_full && !bad_r;
      if (!bad_r) begin
        mem[addr] <= smp_r;
      end
    end
    if (cmd.load_out) begin
      out_r.average     <= quotient[SAMPLE_W-1:0];
      out_r.window_full <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        fill_r[i] <= '0;
        pos_r[i]  <= '0;
      end
    end else if (cmd.upd && !bad_r) begin
      sum_r[ch_r] <= new_sum;
      if (is_full) begin
        pos_r[ch_r] <= pos_inc;
      end else begin
        fill_r[ch_r] <= cur_fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

>>> src/mma_ctrl.sv
// sequencing state machine: accept, store read, update, divide, hand off
module mma_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mma_pkg::sts_t sts,
  output mma_pkg::cmd_t cmd
);
  import mma_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // quotient waits in the divider while the output register is held
        if (sts.div_done && !sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule
